// ===== sv/cmm_pkg.sv =====
// shared types and constants of the complex matrix multiply block
package cmm_pkg;

  localparam int IDX_W   = 3;
  localparam int CFG_W   = 4;
  localparam int OUT_W   = 36;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] FUNC_LOAD_A  = 2'd0;
  localparam logic [1:0] FUNC_LOAD_B  = 2'd1;
  localparam logic [1:0] FUNC_REQUEST = 2'd2;

  localparam logic [1:0] REG_ROWS_OF_A  = 2'd0;
  localparam logic [1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [1:0] REG_COLS_OF_B  = 2'd2;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  localparam logic [CFG_W-1:0] SIZE_RESET = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } cmm_state_t;

  typedef struct packed {
    logic clear;
    logic valid;
  } mac_ctrl_t;

endpackage

// ===== sv/cmm_store.sv =====
// element store for one matrix: one write port, one registered read port
module cmm_store #(
  parameter int DEPTH  = 64,
  parameter int DATA_W = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/cmm_mac.sv =====
// shared complex multiply-accumulate unit: product stage then accumulate stage
module cmm_mac #(
  parameter int ELEM_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cmm_pkg::mac_ctrl_t           ctrl,
  input  logic signed [ELEM_WIDTH-1:0] a_re,
  input  logic signed [ELEM_WIDTH-1:0] a_im,
  input  logic signed [ELEM_WIDTH-1:0] b_re,
  input  logic signed [ELEM_WIDTH-1:0] b_im,
  output logic                         busy,
  output logic [cmm_pkg::OUT_W-1:0]    acc_re,
  output logic [cmm_pkg::OUT_W-1:0]    acc_im
);

  import cmm_pkg::*;

  localparam int PW = 2 * ELEM_WIDTH;
  localparam int SW = (PW + 1 > OUT_W) ? PW + 1 : OUT_W;

  logic signed [PW-1:0] p_rr;
  logic signed [PW-1:0] p_ii;
  logic signed [PW-1:0] p_ri;
  logic signed [PW-1:0] p_ir;
  logic signed [SW-1:0] sum_re;
  logic signed [SW-1:0] sum_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (ctrl.clear) begin
      busy <= 1'b0;
    end else begin
      busy <= ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.valid) begin
      p_rr <= a_re * b_re;
      p_ii <= a_im * b_im;
      p_ri <= a_re * b_im;
      p_ir <= a_im * b_re;
    end
  end

  assign sum_re = SW'(p_rr) - SW'(p_ii);
  assign sum_im = SW'(p_ri) + SW'(p_ir);

  // sums wrap at the output width
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (busy) begin
      acc_re <= acc_re + sum_re[OUT_W-1:0];
      acc_im <= acc_im + sum_im[OUT_W-1:0];
    end
  end

endmodule

// ===== sv/complex_matrix_multiply.sv =====
// Complex matrix product C = A*B with fixed-point Q1.14 elements.
// Input channel (in_valid/in_stall) carries words that load one element of
// A or B (func load A / load B) or request one element of C (func request).
// A load is taken without a stall and gives no output word; out-of-range loads
// and the unused func code are dropped. A request walks the inner dimension
// through one shared complex multiply-accumulate, one term per cycle, and
// returns prod_re/prod_im with 28 fraction bits and status on the output
// channel (out_valid/out_stall). A request with an index outside the
// configured sizes returns zeros with the range status.
// With nk the inner size capped at MAX_DIM, an in-range request holds in_stall
// high through nk term reads, then the read, product and accumulate drain,
// then the output load; with an empty inner dimension there are no term
// reads, and an out-of-range request holds in_stall only until its output
// load. The next word is taken the cycle after the output load.
// The output word sits in a register: while the receiver stalls, loads are
// still taken, and a finished request waits for the register to free up.
// Sizes are written over the APB-style port at 0x0, 0x4, 0x8, by the user only
// while idle, unchecked by the block. Synchronous reset clears control state,
// sets all sizes to 8; element stores hold no defined value until written.
module complex_matrix_multiply #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      func,
  input  logic [cmm_pkg::IDX_W-1:0]       row_index,
  input  logic [cmm_pkg::IDX_W-1:0]       col_index,
  input  logic signed [ELEM_WIDTH-1:0]    elem_re,
  input  logic signed [ELEM_WIDTH-1:0]    elem_im,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [cmm_pkg::OUT_W-1:0] prod_re,
  output logic signed [cmm_pkg::OUT_W-1:0] prod_im,
  output logic                            status,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cmm_pkg::PADDR_W-1:0]     paddr,
  input  logic [cmm_pkg::PDATA_W-1:0]     pwdata,
  output logic [cmm_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready
);

  import cmm_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int KW    = $clog2(MAX_DIM + 1);
  localparam int DW    = 2 * ELEM_WIDTH;

  cmm_state_t state;
  cmm_state_t state_next;

  logic [CFG_W-1:0] rows_of_a;
  logic [CFG_W-1:0] inner_size;
  logic [CFG_W-1:0] cols_of_b;
  logic [KW-1:0]    nr;
  logic [KW-1:0]    nk;
  logic [KW-1:0]    nc;

  logic             in_acc;
  logic             cfg_wr;
  logic             req_in_range;
  logic             load_a_ok;
  logic             load_b_ok;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    a_raddr;
  logic [AW-1:0]    b_raddr;
  logic [DW-1:0]    a_rdata;
  logic [DW-1:0]    b_rdata;

  logic [KW-1:0]    k;
  logic [IDX_W-1:0] req_row;
  logic [IDX_W-1:0] req_col;
  logic             req_err;
  logic             rd_v;
  logic             issue;
  logic             out_load;

  mac_ctrl_t        mac_ctrl;
  logic             mac_busy;
  logic [OUT_W-1:0] acc_re;
  logic [OUT_W-1:0] acc_im;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_of_a  <= SIZE_RESET;
      inner_size <= SIZE_RESET;
      cols_of_b  <= SIZE_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ROWS_OF_A:  rows_of_a  <= pwdata[CFG_W-1:0];
        REG_INNER_SIZE: inner_size <= pwdata[CFG_W-1:0];
        REG_COLS_OF_B:  cols_of_b  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ROWS_OF_A:  prdata = PDATA_W'(rows_of_a);
      REG_INNER_SIZE: prdata = PDATA_W'(inner_size);
      REG_COLS_OF_B:  prdata = PDATA_W'(cols_of_b);
      default:        prdata = '0;
    endcase
  end

  // sizes above the store dimension act as the store dimension
  assign nr = (int'(rows_of_a)  > MAX_DIM) ? KW'(MAX_DIM) : KW'(rows_of_a);
  assign nk = (int'(inner_size) > MAX_DIM) ? KW'(MAX_DIM) : KW'(inner_size);
  assign nc = (int'(cols_of_b)  > MAX_DIM) ? KW'(MAX_DIM) : KW'(cols_of_b);

  assign in_acc = in_valid && (state == ST_IDLE);

  assign load_a_ok    = (int'(row_index) < int'(nr)) && (int'(col_index) < int'(nk));
  assign load_b_ok    = (int'(row_index) < int'(nk)) && (int'(col_index) < int'(nc));
  assign req_in_range = (int'(row_index) < int'(nr)) && (int'(col_index) < int'(nc));

  assign waddr   = AW'(AW'(row_index) * AW'(MAX_DIM)) + AW'(col_index);
  assign a_raddr = AW'(AW'(req_row) * AW'(MAX_DIM)) + AW'(k);
  assign b_raddr = AW'(AW'(k) * AW'(MAX_DIM)) + AW'(req_col);

  cmm_store #(
    .DEPTH  (DEPTH),
    .DATA_W (DW)
  ) u_a_store (
    .clk   (clk),
    .we    (in_acc && (func == FUNC_LOAD_A) && load_a_ok),
    .waddr (waddr),
    .wdata ({elem_re, elem_im}),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  cmm_store #(
    .DEPTH  (DEPTH),
    .DATA_W (DW)
  ) u_b_store (
    .clk   (clk),
    .we    (in_acc && (func == FUNC_LOAD_B) && load_b_ok),
    .waddr (waddr),
    .wdata ({elem_re, elem_im}),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  cmm_mac #(
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .a_re   (a_rdata[DW-1:ELEM_WIDTH]),
    .a_im   (a_rdata[ELEM_WIDTH-1:0]),
    .b_re   (b_rdata[DW-1:ELEM_WIDTH]),
    .b_im   (b_rdata[ELEM_WIDTH-1:0]),
    .busy   (mac_busy),
    .acc_re (acc_re),
    .acc_im (acc_im)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_stall       = 1'b1;
    issue          = 1'b0;
    out_load       = 1'b0;
    mac_ctrl.clear = 1'b0;
    mac_ctrl.valid = rd_v;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && (func == FUNC_REQUEST)) begin
          mac_ctrl.clear = 1'b1;
          state_next     = req_in_range ? ST_RUN : ST_OUT;
        end
      end
      ST_RUN: begin
        if (k != nk) begin
          issue = 1'b1;
        end else if (!rd_v && !mac_busy) begin
          // pipeline drained, sum is final
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
    end else begin
      rd_v <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (func == FUNC_REQUEST)) begin
      k       <= '0;
      req_row <= row_index;
      req_col <= col_index;
      req_err <= !req_in_range;
    end else if (issue) begin
      k <= k + KW'(1);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      prod_re <= req_err ? '0 : acc_re;
      prod_im <= req_err ? '0 : acc_im;
      status  <= req_err ? STATUS_RANGE : STATUS_OK;
    end
  end

  a_range_req_skips_run: assert property (@(posedge clk) disable iff (rst)
    in_acc && (func == FUNC_REQUEST) && !req_in_range |=> state == ST_OUT)
    else $error("out-of-range request did not go straight to output");

  a_k_bounded: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> int'(k) <= int'(nk))
    else $error("term counter ran past the inner size");

  a_err_word_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_RANGE) |-> (prod_re == '0) && (prod_im == '0))
    else $error("range status word carries a nonzero product");

  a_mac_only_in_run: assert property (@(posedge clk) disable iff (rst)
    mac_busy |-> state == ST_RUN)
    else $error("multiply-accumulate active outside a request");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    in_acc && ((func == FUNC_LOAD_A) || (func == FUNC_LOAD_B)) |=> state == ST_IDLE)
    else $error("load word left the idle state");

endmodule

// ===== tb/sv/complex_matrix_multiply_tb.sv =====
// testbench for complex_matrix_multiply: random loads and product requests checked against a predictor
import cmm_pkg::*;

localparam int DIM    = 8;
localparam int ELEM_W = 16;

typedef struct {
  logic signed [OUT_W-1:0] re;
  logic signed [OUT_W-1:0] im;
  logic                    st;
} product_t;

class cmm_product_tracker;
  logic signed [ELEM_W-1:0] a_re[DIM][DIM];
  logic signed [ELEM_W-1:0] a_im[DIM][DIM];
  logic signed [ELEM_W-1:0] b_re[DIM][DIM];
  logic signed [ELEM_W-1:0] b_im[DIM][DIM];
  bit                       a_loaded[DIM][DIM];
  bit                       b_loaded[DIM][DIM];
  logic [CFG_W-1:0]         size_reg[3];
  product_t                 expected_products[$];
  int                       errors;

  function new();
    size_reg[REG_ROWS_OF_A]  = SIZE_RESET;
    size_reg[REG_INNER_SIZE] = SIZE_RESET;
    size_reg[REG_COLS_OF_B]  = SIZE_RESET;
    errors = 0;
  endfunction

  function void write_size(logic [1:0] reg_idx, logic [CFG_W-1:0] value);
    size_reg[reg_idx] = value;
  endfunction

  // sizes above the store depth act as the full depth
  function int dim(logic [1:0] reg_idx);
    return (size_reg[reg_idx] > DIM) ? DIM : int'(size_reg[reg_idx]);
  endfunction

  function int pending();
    return expected_products.size();
  endfunction

  // in-range request that would read an entry never loaded
  function bit needs_load(int r, int c, output bit in_a, output int k_miss);
    int k;
    in_a = 1'b0;
    k_miss = 0;
    if (r >= dim(REG_ROWS_OF_A) || c >= dim(REG_COLS_OF_B)) return 1'b0;
    for (k = 0; k < dim(REG_INNER_SIZE); k++) begin
      if (!a_loaded[r][k]) begin
        in_a = 1'b1;
        k_miss = k;
        return 1'b1;
      end
      if (!b_loaded[k][c]) begin
        k_miss = k;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function void note_word(logic [1:0] f, int r, int c,
                          logic signed [ELEM_W-1:0] re, logic signed [ELEM_W-1:0] im);
    int       nr;
    int       nk;
    int       nc;
    int       k;
    longint   rr;
    longint   ii;
    longint   ri;
    longint   ir;
    product_t p;
    nr = dim(REG_ROWS_OF_A);
    nk = dim(REG_INNER_SIZE);
    nc = dim(REG_COLS_OF_B);
    case (f)
      FUNC_LOAD_A: begin
        if (r < nr && c < nk) begin
          a_re[r][c] = re;
          a_im[r][c] = im;
          a_loaded[r][c] = 1'b1;
        end
      end
      FUNC_LOAD_B: begin
        if (r < nk && c < nc) begin
          b_re[r][c] = re;
          b_im[r][c] = im;
          b_loaded[r][c] = 1'b1;
        end
      end
      FUNC_REQUEST: begin
        p.re = '0;
        p.im = '0;
        p.st = STATUS_OK;
        if (r >= nr || c >= nc) begin
          p.st = STATUS_RANGE;
        end else begin
          for (k = 0; k < nk; k++) begin
            rr = longint'(a_re[r][k]) * longint'(b_re[k][c]);
            ii = longint'(a_im[r][k]) * longint'(b_im[k][c]);
            ri = longint'(a_re[r][k]) * longint'(b_im[k][c]);
            ir = longint'(a_im[r][k]) * longint'(b_re[k][c]);
            // accumulators wrap at the output width
            p.re = p.re + OUT_W'(rr - ii);
            p.im = p.im + OUT_W'(ri + ir);
          end
        end
        expected_products.push_back(p);
      end
      default: ;
    endcase
  endfunction

  function void note_error(string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endfunction

  function void check_product(logic signed [OUT_W-1:0] re, logic signed [OUT_W-1:0] im,
                              logic st);
    product_t p;
    if (expected_products.size() == 0) begin
      note_error($sformatf("unexpected word re %0d im %0d status %0d", re, im, st));
      return;
    end
    p = expected_products.pop_front();
    if (re !== p.re)
      note_error($sformatf("prod_re expected %0d got %0d", p.re, re));
    if (im !== p.im)
      note_error($sformatf("prod_im expected %0d got %0d", p.im, im));
    if (st !== p.st)
      note_error($sformatf("status expected %0d got %0d", p.st, st));
  endfunction
endclass

module complex_matrix_multiply_tb;
  localparam int CYCLE_LIMIT = 400000;
  localparam int QUIET_CYCLES = 16;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic [1:0]               func;
  logic [IDX_W-1:0]         row_index;
  logic [IDX_W-1:0]         col_index;
  logic signed [ELEM_W-1:0] elem_re;
  logic signed [ELEM_W-1:0] elem_im;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [OUT_W-1:0]  prod_re;
  logic signed [OUT_W-1:0]  prod_im;
  logic                     status;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [PADDR_W-1:0]       paddr;
  logic [PDATA_W-1:0]       pwdata;
  logic [PDATA_W-1:0]       prdata;
  logic                     pready;

  cmm_product_tracker products;
  int send_idle_pct;
  int recv_stall_pct;
  int cycle_count;

  complex_matrix_multiply #(
    .MAX_DIM    (DIM),
    .ELEM_WIDTH (ELEM_W)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .row_index (row_index),
    .col_index (col_index),
    .elem_re   (elem_re),
    .elem_im   (elem_im),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .prod_re   (prod_re),
    .prod_im   (prod_im),
    .status    (status),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // receiving side: check each accepted word, then pick the next stall
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        products.check_product(prod_re, prod_im, status);
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_word(input logic [1:0] f, input int r, input int c,
                           input logic [ELEM_W-1:0] re, input logic [ELEM_W-1:0] im);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    func      <= f;
    row_index <= IDX_W'(r);
    col_index <= IDX_W'(c);
    elem_re   <= re;
    elem_im   <= im;
    do @(posedge clk); while (in_stall);
    products.note_word(f, r, c, re, im);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (products.pending() != 0);
  endtask

  task automatic write_size(input logic [1:0] reg_idx, input logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({reg_idx, 2'b00});
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    products.write_size(reg_idx, value);
    @(posedge clk);
  endtask

  // sizes change only once the block has gone quiet
  task automatic set_sizes(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] inner,
                           input logic [CFG_W-1:0] cols);
    wait_for_drain();
    repeat (QUIET_CYCLES) @(posedge clk);
    write_size(REG_ROWS_OF_A, rows);
    write_size(REG_INNER_SIZE, inner);
    write_size(REG_COLS_OF_B, cols);
  endtask

  function automatic logic [ELEM_W-1:0] rand_elem();
    case ($urandom_range(9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'hFFFF;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  function automatic int pick_index(int n);
    if (n > 0 && $urandom_range(3) != 0) return $urandom_range(n - 1);
    return $urandom_range(DIM - 1);
  endfunction

  task automatic random_words(input int quota);
    int done;
    int pick;
    int nr;
    int nk;
    int nc;
    int r;
    int c;
    int k;
    int t;
    bit in_a;
    bit found;
    done = 0;
    nr = products.dim(REG_ROWS_OF_A);
    nk = products.dim(REG_INNER_SIZE);
    nc = products.dim(REG_COLS_OF_B);
    while (done < quota) begin
      if ($urandom_range(199) == 0) wait_for_drain();
      pick = $urandom_range(99);
      if (pick < 4) begin
        send_word(FUNC_UNUSED, $urandom_range(7), $urandom_range(7), rand_elem(), rand_elem());
      end else if (pick < 10) begin
        // loads with any index, mostly dropped when sizes are small
        send_word($urandom_range(1) ? FUNC_LOAD_A : FUNC_LOAD_B, $urandom_range(7),
                  $urandom_range(7), rand_elem(), rand_elem());
      end else if (pick < 42) begin
        if (nr > 0 && nk > 0) begin
          send_word(FUNC_LOAD_A, $urandom_range(nr - 1), $urandom_range(nk - 1),
                    rand_elem(), rand_elem());
          done++;
        end else begin
          send_word(FUNC_LOAD_A, $urandom_range(7), $urandom_range(7), rand_elem(), rand_elem());
        end
      end else if (pick < 74) begin
        if (nk > 0 && nc > 0) begin
          send_word(FUNC_LOAD_B, $urandom_range(nk - 1), $urandom_range(nc - 1),
                    rand_elem(), rand_elem());
          done++;
        end else begin
          send_word(FUNC_LOAD_B, $urandom_range(7), $urandom_range(7), rand_elem(), rand_elem());
        end
      end else begin
        found = 1'b0;
        for (t = 0; t < 8 && !found; t++) begin
          r = pick_index(nr);
          c = pick_index(nc);
          found = !products.needs_load(r, c, in_a, k);
        end
        // no safe request found: load what the last one was missing
        if (found)
          send_word(FUNC_REQUEST, r, c, rand_elem(), rand_elem());
        else if (in_a)
          send_word(FUNC_LOAD_A, r, k, rand_elem(), rand_elem());
        else
          send_word(FUNC_LOAD_B, k, c, rand_elem(), rand_elem());
        done++;
      end
    end
  endtask

  initial begin
    products  = new();
    rst       = 1'b1;
    in_valid  = 1'b0;
    func      = FUNC_LOAD_A;
    row_index = '0;
    col_index = '0;
    elem_re   = '0;
    elem_im   = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    send_idle_pct  = 34;
    recv_stall_pct = 54;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // cols above the store depth behave as eight
    set_sizes(4'd2, 4'd2, 4'd9);
    send_word(FUNC_LOAD_A, 0, 0, 16'h7FFF, 16'h7FFF);
    send_word(FUNC_LOAD_A, 0, 1, 16'h8000, 16'h8000);
    send_word(FUNC_LOAD_B, 0, 7, 16'h7FFF, 16'h8000);
    send_word(FUNC_LOAD_B, 1, 7, 16'h8000, 16'h7FFF);
    send_word(FUNC_REQUEST, 0, 7, 16'hFFFF, 16'hFFFF);
    send_word(FUNC_LOAD_A, 2, 0, 16'h1234, 16'h4321);
    send_word(FUNC_LOAD_A, 0, 2, 16'h1234, 16'h4321);
    send_word(FUNC_LOAD_B, 2, 0, 16'h1234, 16'h4321);
    send_word(FUNC_UNUSED, 0, 0, 16'h5555, 16'hAAAA);
    send_word(FUNC_REQUEST, 2, 0, 16'h0000, 16'h0000);
    send_word(FUNC_REQUEST, 7, 7, 16'h7FFF, 16'h8000);
    send_word(FUNC_LOAD_A, 1, 0, 16'h0001, 16'hFFFF);
    send_word(FUNC_LOAD_A, 1, 1, 16'h0000, 16'h8000);
    send_word(FUNC_LOAD_B, 0, 0, 16'h8000, 16'h0001);
    send_word(FUNC_LOAD_B, 1, 0, 16'h7FFF, 16'h0000);
    send_word(FUNC_REQUEST, 1, 0, 16'hAAAA, 16'h5555);
    send_word(FUNC_REQUEST, 1, 7, 16'h0000, 16'hFFFF);
    send_word(FUNC_LOAD_A, 0, 0, 16'h8000, 16'h8000);
    send_word(FUNC_REQUEST, 0, 7, 16'h0000, 16'h0000);
    send_word(FUNC_REQUEST, 0, 0, 16'hFFFF, 16'h0000);

    set_sizes(4'd8, 4'd8, 4'd8);
    random_words(450);
    set_sizes(4'd1, 4'd1, 4'd1);
    random_words(100);

    send_idle_pct  = 54;
    recv_stall_pct = 34;
    set_sizes(4'd15, 4'd15, 4'd15);
    random_words(350);
    // zero sizes: every load dropped, every request out of range
    set_sizes(4'd0, 4'd0, 4'd0);
    random_words(40);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // empty inner dimension sums no terms
    set_sizes(4'd3, 4'd0, 4'd5);
    random_words(60);
    set_sizes(CFG_W'($urandom_range(1, 12)), CFG_W'($urandom_range(1, 12)),
              CFG_W'($urandom_range(1, 12)));
    random_words(500);

    wait_for_drain();
    repeat (QUIET_CYCLES) @(posedge clk);
    if (products.errors == 0 && products.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
